/* design/mss_pkg.sv */
// Shared types and constants of the motor soft-start direction sequencer.
// Used by the channel interfaces and by every module of the block.
package mss_pkg;

   // Field widths of the command and result words.
   localparam int unsigned SPEED_W    = 16;
   localparam int unsigned CMD_W      = 3;
   localparam int unsigned RES_W      = 5;
   localparam int unsigned RAMP_W     = 17;
   localparam int unsigned TENTH_W    = 13;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // Largest PWM resolution the block supports.
   localparam int unsigned MAX_RESOLUTION = 16;

   // Division by ten as a multiply by a scaled reciprocal; exact for 16-bit inputs.
   localparam int unsigned RECIP_SHIFT = 19;
   localparam logic [16:0] RECIP_TENTH = 17'd52429;
   localparam int unsigned PROD_W      = SPEED_W + 17;

   // Register reset values.
   localparam logic [RES_W-1:0]   RESET_RES_BITS  = 5'd8;
   localparam logic [SPEED_W-1:0] RESET_STOP_WAIT = 16'd500;
   localparam logic [SPEED_W-1:0] RESET_SETTLE    = 16'd50;
   localparam logic [SPEED_W-1:0] RESET_STABILIZE = 16'd100;
   localparam logic [SPEED_W-1:0] RESET_STEP      = 16'd10;
   localparam logic [SPEED_W-1:0] RESET_RAMP_STEP = 16'd25;
   localparam logic [SPEED_W-1:0] RESET_MIN_START = 16'd10;

   // Command codes.
   typedef enum logic [CMD_W-1:0] {
      CMD_TICK      = 3'd0,
      CMD_FORWARD   = 3'd1,
      CMD_REVERSE   = 3'd2,
      CMD_STOP      = 3'd3,
      CMD_SET_SPEED = 3'd4,
      CMD_SET_DIR   = 3'd5
   } cmd_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RESOLUTION = 3'd0,
      CSR_STOP_WAIT  = 3'd1,
      CSR_SETTLE     = 3'd2,
      CSR_STABILIZE  = 3'd3,
      CSR_STEP       = 3'd4,
      CSR_RAMP_STEP  = 3'd5,
      CSR_MIN_START  = 3'd6
   } csr_index_type;

   // Current configuration.
   typedef struct packed {
      logic [RES_W-1:0]   res_bits;
      logic [SPEED_W-1:0] stop_wait;
      logic [SPEED_W-1:0] settle;
      logic [SPEED_W-1:0] stabilize;
      logic [SPEED_W-1:0] step_ticks;
      logic [SPEED_W-1:0] ramp_step;
      logic [SPEED_W-1:0] min_start;
   } cfg_type;

   // Command word after the input register: speed already saturated and divided by ten.
   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [SPEED_W-1:0] speed_sat;
      logic [TENTH_W-1:0] speed_tenth;
      logic               direction;
   } stage_word_type;

   // Status of the sequencer core, watched by the checks at the top level.
   typedef struct packed {
      logic               step;
      logic               taken;
      logic               busy;
      logic [SPEED_W-1:0] duty;
      logic [SPEED_W-1:0] present;
   } core_status_type;

endpackage

/* design/mss_if.sv */
// Valid/ready channel interfaces for command words and result words.
// Depends on mss_pkg for the field widths.
interface mss_req_if;
   logic                         valid;
   logic                         ready;
   logic [mss_pkg::CMD_W-1:0]    command;
   logic [mss_pkg::SPEED_W-1:0]  speed;
   logic                         direction;

   modport source (output valid, command, speed, direction, input ready);
   modport sink (input valid, command, speed, direction, output ready);
endinterface

interface mss_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mss_pkg::SPEED_W-1:0]  duty;
   logic                         reverse_out;
   logic                         busy_res;
   logic                         accepted;
   logic [mss_pkg::SPEED_W-1:0]  speed_now;
   logic                         running;

   modport source (output valid, duty, reverse_out, busy_res, accepted, speed_now, running,
                   input ready);
   modport sink (input valid, duty, reverse_out, busy_res, accepted, speed_now, running,
                 output ready);
endinterface

/* design/mss_csr.sv */
// Configuration registers of the soft-start sequencer, written through a plain write port.
// Depends on mss_pkg for the register layout and indexes.
module mss_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [mss_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mss_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output mss_pkg::cfg_type                  cfg
);

   mss_pkg::cfg_type cfg_ff;
   mss_pkg::cfg_type cfg_in;

   // Decode the write; indexes past the list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (mss_pkg::csr_index_type'(csr_index))
            mss_pkg::CSR_RESOLUTION: cfg_in.res_bits   = csr_wdata[mss_pkg::RES_W-1:0];
            mss_pkg::CSR_STOP_WAIT:  cfg_in.stop_wait  = csr_wdata;
            mss_pkg::CSR_SETTLE:     cfg_in.settle     = csr_wdata;
            mss_pkg::CSR_STABILIZE:  cfg_in.stabilize  = csr_wdata;
            mss_pkg::CSR_STEP:       cfg_in.step_ticks = csr_wdata;
            mss_pkg::CSR_RAMP_STEP:  cfg_in.ramp_step  = csr_wdata;
            mss_pkg::CSR_MIN_START:  cfg_in.min_start  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.res_bits   <= mss_pkg::RESET_RES_BITS;
         cfg_ff.stop_wait  <= mss_pkg::RESET_STOP_WAIT;
         cfg_ff.settle     <= mss_pkg::RESET_SETTLE;
         cfg_ff.stabilize  <= mss_pkg::RESET_STABILIZE;
         cfg_ff.step_ticks <= mss_pkg::RESET_STEP;
         cfg_ff.ramp_step  <= mss_pkg::RESET_RAMP_STEP;
         cfg_ff.min_start  <= mss_pkg::RESET_MIN_START;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/mss_in_stage.sv */
// Input register of the sequencer: saturates the requested speed to full scale
// and divides it by ten before the word reaches the core. Depends on mss_pkg and mss_req_if.
module mss_in_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  mss_pkg::cfg_type        cfg,
   mss_req_if.sink                 req_if,
   output logic                    stage_valid,
   output mss_pkg::stage_word_type stage_word,
   input  logic                    stage_ready
);

   logic                              valid_ff;
   logic                              valid_in;
   mss_pkg::stage_word_type           word_ff;
   mss_pkg::stage_word_type           word_in;
   logic [mss_pkg::RES_W-1:0]         res_eff;
   logic [mss_pkg::RES_W-1:0]         shift_amt;
   logic [mss_pkg::SPEED_W-1:0]       full_scale;
   logic [mss_pkg::SPEED_W-1:0]       speed_sat;
   logic [mss_pkg::SPEED_W-1:0]       scale_src;
   logic [mss_pkg::PROD_W-1:0]        tenth_prod;

   // Resolution outside 1..MAX_RESOLUTION is pulled to the nearest end.
   always_comb begin
      if (cfg.res_bits == '0) begin
         res_eff = mss_pkg::RES_W'(1);
      end else if (cfg.res_bits > mss_pkg::RES_W'(mss_pkg::MAX_RESOLUTION)) begin
         res_eff = mss_pkg::RES_W'(mss_pkg::MAX_RESOLUTION);
      end else begin
         res_eff = cfg.res_bits;
      end
   end

   // Full scale is all ones at the chosen resolution; the request saturates to it.
   assign shift_amt  = mss_pkg::RES_W'(mss_pkg::SPEED_W) - res_eff;
   assign full_scale = {mss_pkg::SPEED_W{1'b1}} >> shift_amt;
   assign speed_sat  = (req_if.speed > full_scale) ? full_scale : req_if.speed;

   // A set-direction word has no speed of its own. It carries full scale and its tenth,
   // so the core can saturate the kept speed against the current resolution.
   assign scale_src  = (req_if.command == mss_pkg::CMD_SET_DIR) ? full_scale : speed_sat;

   // Tenth of the carried speed by reciprocal multiply.
   assign tenth_prod = mss_pkg::PROD_W'(scale_src) * mss_pkg::PROD_W'(mss_pkg::RECIP_TENTH);

   always_comb begin
      word_in.command     = req_if.command;
      word_in.speed_sat   = scale_src;
      word_in.speed_tenth = tenth_prod[mss_pkg::RECIP_SHIFT +: mss_pkg::TENTH_W];
      word_in.direction   = req_if.direction;
   end

   // The register takes a new word when it is empty or the core takes the held one.
   assign req_if.ready = !valid_ff || stage_ready;
   assign valid_in     = req_if.ready ? req_if.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_if.valid && req_if.ready) begin
         word_ff <= word_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_word  = word_ff;

endmodule

/* design/mss_core.sv */
// Sequencer core: phase state, tick countdowns, soft-start ramp and the result register.
// Depends on mss_pkg and mss_rsp_if.
module mss_core (
   input  logic                     clock,
   input  logic                     reset,
   input  mss_pkg::cfg_type         cfg,
   input  logic                     stage_valid,
   input  mss_pkg::stage_word_type  stage_word,
   output logic                     stage_ready,
   mss_rsp_if.source                rsp_if,
   output mss_pkg::core_status_type status
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_STOP,
      PH_SETTLE,
      PH_STAB,
      PH_RAMP
   } phase_type;

   typedef struct packed {
      logic [mss_pkg::SPEED_W-1:0] duty;
      logic                        reverse_out;
      logic                        busy_res;
      logic                        accepted;
      logic [mss_pkg::SPEED_W-1:0] speed_now;
      logic                        running;
   } result_type;

   phase_type                      phase_ff, phase_in;
   logic [mss_pkg::SPEED_W-1:0]    wait_ff, wait_in;
   logic [mss_pkg::SPEED_W-1:0]    duty_ff, duty_in;
   logic [mss_pkg::RAMP_W-1:0]     ramp_ff, ramp_in;
   logic [mss_pkg::SPEED_W-1:0]    target_ff, target_in;
   logic [mss_pkg::TENTH_W-1:0]    tenth_ff, tenth_in;
   logic [mss_pkg::SPEED_W-1:0]    present_ff, present_in;
   logic [mss_pkg::TENTH_W-1:0]    ptenth_ff, ptenth_in;
   logic                           rev_ff, rev_in;
   logic                           goal_ff, goal_in;
   logic                           out_valid_ff;
   result_type                     result_ff, result_in;

   logic                           step;
   logic                           taken;
   logic                           busy_now;
   logic                           adv;
   logic                           start;
   logic                           start_rev;
   logic                           finish_now;
   logic [mss_pkg::SPEED_W-1:0]    start_speed;
   logic [mss_pkg::TENTH_W-1:0]    start_tenth;
   logic [mss_pkg::SPEED_W-1:0]    start_level;
   logic [mss_pkg::SPEED_W-1:0]    step_eff;

   // The result register frees up when it is empty or its word is taken.
   assign stage_ready = !out_valid_ff || rsp_if.ready;
   assign step        = stage_valid && stage_ready;
   assign busy_now    = (phase_ff != PH_IDLE);
   assign step_eff    = (cfg.ramp_step == '0) ? mss_pkg::SPEED_W'(1) : cfg.ramp_step;

   // Next state: command decode, then the phase chain that zero-length waits fall through.
   always_comb begin
      phase_in    = phase_ff;
      wait_in     = wait_ff;
      duty_in     = duty_ff;
      ramp_in     = ramp_ff;
      target_in   = target_ff;
      tenth_in    = tenth_ff;
      present_in  = present_ff;
      ptenth_in   = ptenth_ff;
      rev_in      = rev_ff;
      goal_in     = goal_ff;
      taken       = 1'b0;
      adv         = 1'b0;
      start       = 1'b0;
      start_rev   = 1'b0;
      finish_now  = 1'b0;
      start_speed = stage_word.speed_sat;
      start_tenth = stage_word.speed_tenth;
      start_level = '0;

      unique case (mss_pkg::cmd_type'(stage_word.command))
         mss_pkg::CMD_TICK: begin
            taken = 1'b1;
            if (busy_now) begin
               if (wait_ff != '0) begin
                  wait_in = wait_ff - mss_pkg::SPEED_W'(1);
               end
               adv = (wait_in == '0);
            end
         end
         mss_pkg::CMD_FORWARD: begin
            taken     = !busy_now;
            start     = !busy_now;
            start_rev = 1'b0;
         end
         mss_pkg::CMD_REVERSE: begin
            taken     = !busy_now;
            start     = !busy_now;
            start_rev = 1'b1;
         end
         mss_pkg::CMD_STOP: begin
            taken = !busy_now;
            if (!busy_now) begin
               duty_in    = '0;
               present_in = '0;
            end
         end
         mss_pkg::CMD_SET_SPEED: begin
            taken     = !busy_now;
            start     = !busy_now;
            start_rev = (present_ff != '0) ? rev_ff : 1'b0;
         end
         mss_pkg::CMD_SET_DIR: begin
            taken     = !busy_now;
            start     = !busy_now;
            start_rev = stage_word.direction;
            // The kept speed saturates to the full scale carried by the word.
            if (present_ff > stage_word.speed_sat) begin
               start_speed = stage_word.speed_sat;
               start_tenth = stage_word.speed_tenth;
            end else begin
               start_speed = present_ff;
               start_tenth = ptenth_ff;
            end
         end
         default: ;
      endcase

      // A new move; reversing a running motor first drops the duty and waits.
      if (start) begin
         target_in = start_speed;
         tenth_in  = start_tenth;
         goal_in   = start_rev;
         phase_in  = PH_STOP;
         if ((rev_ff != start_rev) && (present_ff != '0)) begin
            duty_in    = '0;
            present_in = '0;
            wait_in    = cfg.stop_wait;
         end else begin
            wait_in = '0;
         end
         adv = (wait_in == '0);
      end

      // Stop wait over: drive the direction line and settle.
      if (adv && (phase_in == PH_STOP)) begin
         phase_in = PH_SETTLE;
         wait_in  = cfg.settle;
         adv      = (wait_in == '0);
      end

      // Settled: jump to the starting duty, or finish at once for a zero target.
      if (adv && (phase_in == PH_SETTLE)) begin
         if (target_in == '0) begin
            finish_now = 1'b1;
            adv        = 1'b0;
         end else begin
            start_level = (mss_pkg::SPEED_W'(tenth_in) < cfg.min_start) ?
                          cfg.min_start : mss_pkg::SPEED_W'(tenth_in);
            duty_in  = start_level;
            ramp_in  = mss_pkg::RAMP_W'(start_level);
            phase_in = PH_STAB;
            wait_in  = cfg.stabilize;
            adv      = (wait_in == '0);
         end
      end

      // Ramp step. With a zero step hold the ramp runs through to the target in one go.
      if (adv && ((phase_in == PH_STAB) || (phase_in == PH_RAMP))) begin
         if (phase_in == PH_RAMP) begin
            ramp_in = ramp_in + mss_pkg::RAMP_W'(step_eff);
         end
         phase_in = PH_RAMP;
         if (ramp_in < mss_pkg::RAMP_W'(target_in)) begin
            duty_in = ramp_in[mss_pkg::SPEED_W-1:0];
            wait_in = cfg.step_ticks;
            if (cfg.step_ticks == '0) begin
               finish_now = 1'b1;
            end
         end else begin
            finish_now = 1'b1;
         end
      end

      // End of a sequence: target reached, direction committed.
      if (finish_now) begin
         duty_in    = target_in;
         present_in = target_in;
         ptenth_in  = tenth_in;
         rev_in     = goal_in;
         phase_in   = PH_IDLE;
         wait_in    = '0;
      end
   end

   // Result word seen after this step.
   always_comb begin
      result_in.duty        = duty_in;
      result_in.reverse_out = ((phase_in == PH_IDLE) || (phase_in == PH_STOP)) ? rev_in : goal_in;
      result_in.busy_res    = (phase_in != PH_IDLE);
      result_in.accepted    = taken;
      result_in.speed_now   = present_in;
      result_in.running     = (present_in != '0);
   end

   // State and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         wait_ff      <= '0;
         duty_ff      <= '0;
         ramp_ff      <= '0;
         target_ff    <= '0;
         tenth_ff     <= '0;
         present_ff   <= '0;
         ptenth_ff    <= '0;
         rev_ff       <= 1'b0;
         goal_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            phase_ff   <= phase_in;
            wait_ff    <= wait_in;
            duty_ff    <= duty_in;
            ramp_ff    <= ramp_in;
            target_ff  <= target_in;
            tenth_ff   <= tenth_in;
            present_ff <= present_in;
            ptenth_ff  <= ptenth_in;
            rev_ff     <= rev_in;
            goal_ff    <= goal_in;
         end
         out_valid_ff <= step || (out_valid_ff && !rsp_if.ready);
      end
      if (step) begin
         result_ff <= result_in;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.duty        = result_ff.duty;
   assign rsp_if.reverse_out = result_ff.reverse_out;
   assign rsp_if.busy_res    = result_ff.busy_res;
   assign rsp_if.accepted    = result_ff.accepted;
   assign rsp_if.speed_now   = result_ff.speed_now;
   assign rsp_if.running     = result_ff.running;

   always_comb begin
      status.step    = step;
      status.taken   = taken;
      status.busy    = busy_now;
      status.duty    = duty_ff;
      status.present = present_ff;
   end

endmodule

/* design/motor_soft_start_direction_sequencer.sv */
// Top level of the DC motor soft-start sequencer with direction interlock.
// Depends on mss_pkg, mss_if, mss_csr, mss_in_stage and mss_core.
//
// Usage:
//   req_if carries one command word per handshake: command (tick, forward, reverse,
//   stop, set speed, set direction), speed and direction. Tick words pace every wait.
//   rsp_if returns exactly one result word per command word, in order: duty,
//   reverse_out, busy_res, accepted, speed_now and running.
//   csr_wr_en, csr_index and csr_wdata write the seven timing and scaling registers;
//   write them only while no command word is in flight.
// Pipeline:
//   A command word passes the input register (speed saturation and divide by ten),
//   then the sequencer core, whose state update and result register close in the
//   same cycle; the result word turns valid once the core has registered it.
//   One word is accepted every cycle while the result side keeps up.
// Reset:
//   Synchronous reset puts the motor at zero duty, forward, idle, and loads the
//   register defaults. No word is pending after reset.
// Stalls:
//   While rsp_if.ready is low the result word holds; the input register still takes
//   one more word, after which req_if.ready drops until the result side drains.
module motor_soft_start_direction_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   mss_req_if.sink                           req_if,
   mss_rsp_if.source                         rsp_if,
   input  logic                              csr_wr_en,
   input  logic [mss_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mss_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   mss_pkg::cfg_type         cfg;
   logic                     stage_valid;
   logic                     stage_ready;
   mss_pkg::stage_word_type  stage_word;
   mss_pkg::core_status_type status;

   // Configuration registers.
   mss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Input register with speed saturation and scaling.
   mss_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_if      (req_if),
      .stage_valid (stage_valid),
      .stage_word  (stage_word),
      .stage_ready (stage_ready)
   );

   // Sequencer state and result register.
   mss_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .stage_valid (stage_valid),
      .stage_word  (stage_word),
      .stage_ready (stage_ready),
      .rsp_if      (rsp_if),
      .status      (status)
   );

`ifndef SYNTHESIS
   // When idle, the driven duty always equals the completed speed.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.busy_res) |-> (rsp_if.duty == rsp_if.speed_now))
      else $error("idle result with duty different from speed_now");

   // A rejected command leaves duty, speed and busy untouched.
   assert property (@(posedge clock) disable iff (reset)
      (status.step && !status.taken) |=>
         ($stable(status.duty) && $stable(status.present) && $stable(status.busy)))
      else $error("rejected command changed the sequencer state");

   // A sequence only starts from a word that was taken.
   assert property (@(posedge clock) disable iff (reset)
      $rose(status.busy) |-> $past(status.step && status.taken))
      else $error("sequence started without a taken command");
`endif

endmodule
